// File: hw/rtl/sbrp_pkg.sv
// Shared types, codes and constants for the servo bus response parser.
package sbrp_pkg;

    localparam int MAX_PAYLOAD   = 4;
    localparam int PACK_BYTES    = (MAX_PAYLOAD < 4) ? MAX_PAYLOAD : 4;
    localparam int STORE_IDX_W   = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int IDX_W         = 3;
    localparam int TICK_W        = 24;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 24;

    localparam logic [7:0]        BUS_HEADER = 8'h55;
    localparam logic [7:0]        BYTE_MASK  = 8'hff;
    localparam logic [TICK_W-1:0] TICK_MAX   = {TICK_W{1'b1}};

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CSUM    = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ID      = 3'd0,
        CFG_LENGTH  = 3'd1,
        CFG_COMMAND = 3'd2,
        CFG_TIMEOUT = 3'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_HDR1 = 4'd1,
        PH_HDR2 = 4'd2,
        PH_ID   = 4'd3,
        PH_LEN  = 4'd4,
        PH_CMD  = 4'd5,
        PH_DATA = 4'd6,
        PH_CSUM = 4'd7
    } phase_t;

    typedef struct packed {
        logic [7:0]        id;
        logic [2:0]        length;
        logic [7:0]        command;
        logic [TICK_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [31:0] payload;
    } result_t;

    // Payload byte count: length minus three, floored at zero, capped at MAX_PAYLOAD.
    function automatic logic [IDX_W-1:0] payload_count(input logic [2:0] len);
        logic [IDX_W-1:0] n;
        n = (len >= 3'd3) ? IDX_W'(len - 3'd3) : '0;
        if (int'(n) > MAX_PAYLOAD)
            n = IDX_W'(MAX_PAYLOAD);
        return n;
    endfunction

endpackage

// File: hw/rtl/sbrp_frame_fsm.sv
// Frame state machine: header hunt, field match, payload capture, checksum and timeout.
module sbrp_frame_fsm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  sbrp_pkg::op_t        op,
    input  logic [7:0]           rx_byte,
    input  sbrp_pkg::cfg_t       cfg,
    output sbrp_pkg::result_t    res,
    output logic                 awaiting
);
    import sbrp_pkg::*;

    phase_t            phase_reg,  phase_next;
    logic [IDX_W-1:0]  index_reg,  index_next;
    logic [7:0]        sum_reg,    sum_next;
    logic [TICK_W-1:0] tick_reg,   tick_next;
    logic [7:0]        store_reg [MAX_PAYLOAD];
    logic              store_we;
    logic [TICK_W-1:0] tick_inc;
    logic [IDX_W-1:0]  pcnt;
    logic [IDX_W-1:0]  index_inc;
    logic [31:0]       packed_payload;

    assign pcnt      = payload_count(cfg.length);
    assign tick_inc  = (tick_reg < TICK_MAX) ? tick_reg + 1'b1 : tick_reg;
    assign index_inc = index_reg + 1'b1;
    assign awaiting  = (phase_reg != PH_IDLE);

    always_comb begin
        packed_payload = '0;
        for (int i = 0; i < PACK_BYTES; i++) begin
            if (IDX_W'(i) < pcnt)
                packed_payload[8*i +: 8] = store_reg[i];
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        sum_next    = sum_reg;
        tick_next   = tick_reg;
        store_we    = 1'b0;
        res         = '0;
        res.status  = ST_OK;
        if (op == OP_START) begin
            phase_next = PH_HDR1;
            index_next = '0;
            sum_next   = '0;
            tick_next  = '0;
        end else if (phase_reg != PH_IDLE) begin
            if (op == OP_TICK) begin
                tick_next = tick_inc;
                if (tick_inc > cfg.timeout) begin
                    phase_next = PH_IDLE;
                    res.valid  = 1'b1;
                    res.status = ST_TIMEOUT;
                end
            end else if (op == OP_BYTE) begin
                case (phase_reg)
                    PH_HDR1: begin
                        if (rx_byte == BUS_HEADER)
                            phase_next = PH_HDR2;
                    end
                    PH_HDR2: begin
                        phase_next = (rx_byte == BUS_HEADER) ? PH_ID : PH_HDR1;
                    end
                    PH_ID: begin
                        if (rx_byte == cfg.id) begin
                            sum_next   = rx_byte;
                            phase_next = PH_LEN;
                        end else begin
                            phase_next = PH_HDR1;
                        end
                    end
                    PH_LEN: begin
                        if (rx_byte == {5'd0, cfg.length}) begin
                            sum_next   = sum_reg + rx_byte;
                            phase_next = PH_CMD;
                        end else begin
                            phase_next = PH_HDR1;
                        end
                    end
                    PH_CMD: begin
                        if (rx_byte == cfg.command) begin
                            sum_next   = sum_reg + rx_byte;
                            index_next = '0;
                            phase_next = (pcnt != '0) ? PH_DATA : PH_CSUM;
                        end else begin
                            phase_next = PH_HDR1;
                        end
                    end
                    PH_DATA: begin
                        store_we   = (int'(index_reg) < MAX_PAYLOAD);
                        sum_next   = sum_reg + rx_byte;
                        index_next = index_inc;
                        if (index_inc >= pcnt)
                            phase_next = PH_CSUM;
                    end
                    PH_CSUM: begin
                        phase_next = PH_IDLE;
                        res.valid  = 1'b1;
                        if (rx_byte == (~sum_reg & BYTE_MASK)) begin
                            res.status  = ST_OK;
                            res.payload = packed_payload;
                        end else begin
                            res.status  = ST_CSUM;
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            index_reg <= '0;
            sum_reg   <= '0;
            tick_reg  <= '0;
        end else if (item_valid) begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            sum_reg   <= sum_next;
            tick_reg  <= tick_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_valid && store_we)
            store_reg[index_reg[STORE_IDX_W-1:0]] <= rx_byte;
    end

endmodule

// File: hw/rtl/servo_bus_response_parser.sv
// Top level of the servo bus response parser: registers, handshakes and frame FSM.
//
//   channel  direction  handshake              payload
//   s_       in         s_valid / s_ready      s_operation[1:0], s_rx_byte[7:0]
//   m_       out        m_valid / m_ready      m_status[1:0], m_payload[31:0]
//   cfg_     in         cfg_valid / cfg_ready  cfg_index[2:0], cfg_data[23:0]
//
// One beat per cycle sustained while no result waits untaken: a beat lands
// in the input register, is processed by the frame FSM once the output
// register can take a result, and its result (if any) is loaded there.
// The input register refills in the cycle it drains unless the output
// register holds an untaken result. Reset is synchronous on aresetn and
// clears control state and the configuration registers to their defaults.
module servo_bus_response_parser (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic [7:0]                         s_rx_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [31:0]                        m_payload,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sbrp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbrp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sbrp_pkg::*;

    // Input register
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [7:0]  in_byte_reg;

    // Output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [31:0] out_payload_reg;

    cfg_t        cfg_reg;
    result_t     core_res;
    logic        core_awaiting;
    logic        advance;

    // Process the held beat when the output register can take a result.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_valid   = out_valid_reg;
    assign m_status  = out_status_reg;
    assign m_payload = out_payload_reg;

    // Capture the input beat; drop the held one once it is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= op_t'(s_operation);
            in_byte_reg <= s_rx_byte;
        end
    end

    // Configuration writes take effect at once; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.id      <= 8'd0;
            cfg_reg.length  <= 3'd3;
            cfg_reg.command <= 8'd0;
            cfg_reg.timeout <= TICK_W'(1000);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ID:      cfg_reg.id      <= cfg_data[7:0];
                CFG_LENGTH:  cfg_reg.length  <= cfg_data[2:0];
                CFG_COMMAND: cfg_reg.command <= cfg_data[7:0];
                CFG_TIMEOUT: cfg_reg.timeout <= cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sbrp_frame_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .op         (in_op_reg),
        .rx_byte    (in_byte_reg),
        .cfg        (cfg_reg),
        .res        (core_res),
        .awaiting   (core_awaiting)
    );

    // Load a result on advance; hold it until the sink takes the beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && core_res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && core_res.valid) begin
            out_status_reg  <= core_res.status;
            out_payload_reg <= core_res.payload;
        end
    end

`ifndef SYNTHESIS
    // Error and timeout results never carry payload bits.
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_payload == 32'd0))
        else $error("non-ok result carries payload");

    // Input backpressure only arises from a held beat behind a stalled result.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled without a stalled result");

    // Every delivered result ends the reply.
    a_result_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && core_res.valid) |=> !core_awaiting)
        else $error("fsm still awaiting after a result");
`endif

endmodule
